/* rtl/rbim_pkg.sv */
// Shared types and constants for the ring buffer index manager.
// No dependencies; every other file imports this package.
package rbim_pkg;

    // Fixed field widths
    localparam int KindW     = 3;
    localparam int FieldW    = 10;
    localparam int SlotW     = 11;
    localparam logic [SlotW-1:0] SlotReset = 11'd1024;

    // Request kinds; codes five to seven are ignored
    typedef enum logic [KindW-1:0] {
        KIND_RESERVE     = 3'd0,
        KIND_COMMIT      = 3'd1,
        KIND_PEEK        = 3'd2,
        KIND_REL_EXACT   = 3'd3,
        KIND_REL_UPTO    = 3'd4
    } t_kind;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_STATUS
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture request and pre-state counts
        logic apply;    // compute result fields, move pointers
        logic finish;   // compute post-state status, fill output word
    } t_dp_cmd;

endpackage

/* rtl/rbim_ctrl.sv */
// Controller state machine for the ring buffer index manager.
// Depends on rbim_pkg; drives the handshakes and the datapath commands.
module rbim_ctrl import rbim_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   in_acc;
    logic   slot_free;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                n_state = ST_STATUS;
            end
            ST_STATUS: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
            end
            ST_STATUS: begin
                o_cmd.finish = slot_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // State and output word flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

    // An accepted word walks through apply and status
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_APPLY) ##1 (r_state == ST_STATUS))
        else $error("accepted word did not advance through apply and status");

    // Status waits while the output word is still held
    a_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STATUS && r_out_valid && i_out_stall) |=> (r_state == ST_STATUS))
        else $error("status stage left while output word was stalled");

    // A new output word only comes from the status stage
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_STATUS))
        else $error("output word raised outside the status stage");

endmodule

/* rtl/rbim_datapath.sv */
// Datapath for the ring buffer index manager: capacity, head and tail
// pointers, request arithmetic and the output word. Depends on rbim_pkg.
module rbim_datapath import rbim_pkg::*; #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic                i_cfg_wen,
    input  logic [SlotW-1:0]    i_cfg_wdata,
    input  logic [KindW-1:0]    i_kind,
    input  logic [FieldW-1:0]   i_request_count,
    output logic [FieldW-1:0]   o_start_offset,
    output logic [FieldW-1:0]   o_first_run,
    output logic [FieldW-1:0]   o_second_run,
    output logic [FieldW-1:0]   o_granted,
    output logic [FieldW-1:0]   o_used_count,
    output logic [FieldW-1:0]   o_free_count,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic                o_error
);

    localparam int PW = $clog2(MAX_SLOTS);
    localparam int CW = PW + 1;
    localparam int AW = (CW > SlotW) ? CW : SlotW;
    localparam logic [CW-1:0] CapReset = CW'((MAX_SLOTS < 1024) ? MAX_SLOTS : 1024);
    localparam logic [AW-1:0] CapMax   = AW'(MAX_SLOTS);
    localparam logic [AW-1:0] CapMin   = AW'(2);

    // Control state
    logic [CW-1:0] r_cap;
    logic [PW-1:0] r_wp, r_rp;

    // Request stage
    logic [KindW-1:0] r_kind;
    logic [AW-1:0]    r_n, r_used, r_free;

    // Result stage
    logic [FieldW-1:0] r_start, r_first, r_second, r_granted;
    logic              r_err;

    // Output word
    logic [FieldW-1:0] r_o_start, r_o_first, r_o_second, r_o_granted;
    logic [FieldW-1:0] r_o_used, r_o_free;
    logic              r_o_empty, r_o_full, r_o_err;

    logic [AW-1:0] cap_e, wp_e, rp_e, wd_e, cap_wr;
    logic [AW-1:0] used_now, free_now;
    logic [AW-1:0] base, m, m_clamp, room, first_s, second_s, adv;
    logic [AW-1:0] start, granted, rsv_first, rsv_second;
    logic          err, is_rsv, upd_wp, upd_rp;
    logic [PW-1:0] n_ptr;

    assign cap_e = AW'(r_cap);
    assign wp_e  = AW'(r_wp);
    assign rp_e  = AW'(r_rp);

    // Clamp a written capacity into the legal range
    assign wd_e = AW'(i_cfg_wdata);
    always_comb begin
        priority if (wd_e < CapMin) begin
            cap_wr = CapMin;
        end else if (wd_e > CapMax) begin
            cap_wr = CapMax;
        end else begin
            cap_wr = wd_e;
        end
    end

    // Occupancy of the current pointers
    assign used_now = (rp_e <= wp_e) ? (wp_e - rp_e) : (cap_e - rp_e + wp_e);
    assign free_now = cap_e - AW'(1) - used_now;

    // Free runs for a reserve
    always_comb begin
        rsv_second = '0;
        priority if (rp_e > wp_e) begin
            rsv_first = rp_e - wp_e - AW'(1);
        end else if (rp_e == '0) begin
            rsv_first = cap_e - wp_e - AW'(1);
        end else begin
            rsv_first  = cap_e - wp_e;
            rsv_second = rp_e - AW'(1);
        end
    end

    // Per-kind decode: start, run length, error, pointer to move
    assign m_clamp = (r_n < r_used) ? r_n : r_used;
    always_comb begin
        base    = wp_e;
        m       = '0;
        start   = '0;
        granted = '0;
        err     = 1'b0;
        is_rsv  = 1'b0;
        upd_wp  = 1'b0;
        upd_rp  = 1'b0;
        unique case (r_kind)
            KIND_RESERVE: begin
                start   = wp_e;
                granted = r_free;
                is_rsv  = 1'b1;
            end
            KIND_COMMIT: begin
                start = wp_e;
                if (r_n > r_free) begin
                    err = 1'b1;
                end else begin
                    m       = r_n;
                    granted = r_n;
                    upd_wp  = 1'b1;
                end
            end
            KIND_PEEK: begin
                start   = rp_e;
                base    = rp_e;
                granted = r_used;
                if (r_n != '0 && r_used != '0) m = m_clamp;
            end
            KIND_REL_EXACT: begin
                start = rp_e;
                base  = rp_e;
                if (r_n == '0 || r_n > r_used) begin
                    err = 1'b1;
                end else begin
                    m       = r_n;
                    granted = r_n;
                    upd_rp  = 1'b1;
                end
            end
            KIND_REL_UPTO: begin
                start   = rp_e;
                base    = rp_e;
                m       = m_clamp;
                granted = m_clamp;
                upd_rp  = 1'b1;
            end
            default: begin
                start = '0;
            end
        endcase
    end

    // Split the run at the buffer end and advance the pointer
    assign room     = cap_e - base;
    assign first_s  = (m < room) ? m : room;
    assign second_s = m - first_s;
    always_comb begin
        adv = base + m;
        if (adv >= cap_e) adv = adv - cap_e;
    end
    assign n_ptr = PW'(adv);

    // Capacity and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CapReset;
            r_wp  <= '0;
            r_rp  <= '0;
        end else if (i_cfg_wen) begin
            r_cap <= CW'(cap_wr);
            r_wp  <= '0;
            r_rp  <= '0;
        end else if (i_cmd.apply) begin
            if (upd_wp) r_wp <= n_ptr;
            if (upd_rp) r_rp <= n_ptr;
        end
    end

    // Request, result and output words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_n    <= AW'(i_request_count);
            r_used <= used_now;
            r_free <= free_now;
        end
        if (i_cmd.apply) begin
            r_start   <= FieldW'(start);
            r_first   <= FieldW'(is_rsv ? rsv_first : first_s);
            r_second  <= FieldW'(is_rsv ? rsv_second : second_s);
            r_granted <= FieldW'(granted);
            r_err     <= err;
        end
        if (i_cmd.finish) begin
            r_o_start   <= r_start;
            r_o_first   <= r_first;
            r_o_second  <= r_second;
            r_o_granted <= r_granted;
            r_o_err     <= r_err;
            r_o_used    <= FieldW'(used_now);
            r_o_free    <= FieldW'(free_now);
            r_o_empty   <= (r_wp == r_rp);
            r_o_full    <= (free_now == '0);
        end
    end

    assign o_start_offset = r_o_start;
    assign o_first_run    = r_o_first;
    assign o_second_run   = r_o_second;
    assign o_granted      = r_o_granted;
    assign o_used_count   = r_o_used;
    assign o_free_count   = r_o_free;
    assign o_is_empty     = r_o_empty;
    assign o_is_full      = r_o_full;
    assign o_error        = r_o_err;

    // Pointers stay inside the capacity
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wp_e < cap_e) && (rp_e < cap_e))
        else $error("pointer at or beyond capacity");

    // Capacity stays in its legal range
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cap_e >= CapMin) && (cap_e <= CapMax))
        else $error("capacity out of range");

    // A rejected request grants nothing
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply |=> (!r_err || (r_granted == '0 && r_first == '0 && r_second == '0)))
        else $error("rejected request reported a run");

endmodule

/* rtl/ring_buffer_index_manager.sv */
// Top level of the ring buffer index manager: controller plus datapath.
// Depends on rbim_pkg, rbim_ctrl and rbim_datapath.
//
//   channel   direction   handshake                  payload
//   in        input       i_in_valid / o_in_stall    i_kind, i_request_count
//   out       output      o_out_valid / i_out_stall  o_start_offset .. o_error
//   cfg       input       i_cfg_wen                  i_cfg_wdata (slot_count)
//
// A request passes through three steps: accept, apply (run split and pointer move),
// status (occupancy after the move), set by the controller's three states.
// The next request is accepted the cycle after status while the output word waits.
// Status holds while a previous output word is still stalled.
// Synchronous active-low reset; capacity resets to 1024 (or MAX_SLOTS), pointers to 0.
// A capacity write also empties the buffer.
module ring_buffer_index_manager import rbim_pkg::*; #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [SlotW-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KindW-1:0]    i_kind,
    input  logic [FieldW-1:0]   i_request_count,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [FieldW-1:0]   o_start_offset,
    output logic [FieldW-1:0]   o_first_run,
    output logic [FieldW-1:0]   o_second_run,
    output logic [FieldW-1:0]   o_granted,
    output logic [FieldW-1:0]   o_used_count,
    output logic [FieldW-1:0]   o_free_count,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic                o_error
);

    t_dp_cmd cmd;

    rbim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    rbim_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_request_count (i_request_count),
        .o_start_offset  (o_start_offset),
        .o_first_run     (o_first_run),
        .o_second_run    (o_second_run),
        .o_granted       (o_granted),
        .o_used_count    (o_used_count),
        .o_free_count    (o_free_count),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full),
        .o_error         (o_error)
    );

endmodule

/* tb/sv/tb_rbim_report_pkg.sv */
// Report type and scoreboard for the ring buffer index manager testbench.
// Depends on rbim_pkg for field widths, request kinds and the reset capacity.
package tb_rbim_report_pkg;
    import rbim_pkg::*;

    // One output word, fields in port order
    typedef struct packed {
        logic [FieldW-1:0] start_offset;
        logic [FieldW-1:0] first_run;
        logic [FieldW-1:0] second_run;
        logic [FieldW-1:0] granted;
        logic [FieldW-1:0] used_count;
        logic [FieldW-1:0] free_count;
        logic              is_empty;
        logic              is_full;
        logic              error;
    } t_report;

    // Tracks head, tail and capacity, predicts each report and checks words in order
    class ring_report_board;
        int unsigned      max_slots;
        logic [SlotW-1:0] slot_reg;
        int unsigned      head;
        int unsigned      tail;
        t_report          due_reports[$];
        int unsigned      failures;
        int unsigned      checked;

        function new(int unsigned max_slots_in);
            max_slots = max_slots_in;
            slot_reg  = SlotReset;
            head      = 0;
            tail      = 0;
            failures  = 0;
            checked   = 0;
        endfunction

        // A capacity write also empties the buffer
        function void set_slot_count(logic [SlotW-1:0] value);
            slot_reg = value;
            head     = 0;
            tail     = 0;
        endfunction

        // Clamp the register to the usable range
        function int unsigned live_slots();
            if (slot_reg < 2) begin
                return 2;
            end
            if (slot_reg > max_slots) begin
                return max_slots;
            end
            return slot_reg;
        endfunction

        function int unsigned occupancy();
            if (tail <= head) begin
                return head - tail;
            end
            return live_slots() - tail + head;
        endfunction

        function int unsigned free_slots();
            return live_slots() - 1 - occupancy();
        endfunction

        function int unsigned step_ahead(int unsigned ptr, int unsigned n);
            int unsigned sum = ptr + n;
            if (sum >= live_slots()) begin
                sum -= live_slots();
            end
            return sum;
        endfunction

        // Split a run starting at ptr at the end of the buffer
        function void cut_run(int unsigned ptr, int unsigned n,
                              output int unsigned first, output int unsigned second);
            int unsigned room = live_slots() - ptr;
            first  = (n < room) ? n : room;
            second = n - first;
        endfunction

        // Predict the report of an accepted request and advance the pointers
        function void note_request(logic [KindW-1:0] kind, logic [FieldW-1:0] count);
            int unsigned c       = live_slots();
            int unsigned used    = occupancy();
            int unsigned room    = c - 1 - used;
            int unsigned n       = count;
            int unsigned start   = 0;
            int unsigned first   = 0;
            int unsigned second  = 0;
            int unsigned granted = 0;
            bit          err     = 1'b0;
            t_report     rep;

            case (kind)
                KIND_RESERVE: begin
                    start   = head;
                    granted = room;
                    if (tail > head) begin
                        first = tail - head - 1;
                    end else if (tail == 0) begin
                        // separator sits in the last slot
                        first = c - head - 1;
                    end else begin
                        first  = c - head;
                        second = tail - 1;
                    end
                end
                KIND_COMMIT: begin
                    start = head;
                    if (n > room) begin
                        err = 1'b1;
                    end else begin
                        cut_run(head, n, first, second);
                        granted = n;
                        head    = step_ahead(head, n);
                    end
                end
                KIND_PEEK: begin
                    start   = tail;
                    granted = used;
                    if (n != 0 && used != 0) begin
                        cut_run(tail, (n < used) ? n : used, first, second);
                    end
                end
                KIND_REL_EXACT, KIND_REL_UPTO: begin
                    start = tail;
                    if (kind == KIND_REL_UPTO && n > used) begin
                        n = used;
                    end
                    if (kind == KIND_REL_EXACT && (n == 0 || n > used)) begin
                        err = 1'b1;
                    end else begin
                        cut_run(tail, n, first, second);
                        granted = n;
                        tail    = step_ahead(tail, n);
                    end
                end
                default: begin
                end
            endcase

            // Status after the request
            rep.start_offset = FieldW'(start);
            rep.first_run    = FieldW'(first);
            rep.second_run   = FieldW'(second);
            rep.granted      = FieldW'(granted);
            rep.used_count   = FieldW'(occupancy());
            rep.free_count   = FieldW'(free_slots());
            rep.is_empty     = (head == tail);
            rep.is_full      = (free_slots() == 0);
            rep.error        = err;
            due_reports.push_back(rep);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $error("%s: expected %0d, actual %0d", name, want, seen);
                failures++;
            end
        endfunction

        // Compare an accepted word against the oldest prediction
        function void check_report(t_report seen);
            t_report want;
            if (due_reports.size() == 0) begin
                $error("report word with no request outstanding");
                failures++;
                return;
            end
            want = due_reports.pop_front();
            checked++;
            compare_field("start_offset", want.start_offset, seen.start_offset);
            compare_field("first_run", want.first_run, seen.first_run);
            compare_field("second_run", want.second_run, seen.second_run);
            compare_field("granted", want.granted, seen.granted);
            compare_field("used_count", want.used_count, seen.used_count);
            compare_field("free_count", want.free_count, seen.free_count);
            compare_field("is_empty", want.is_empty, seen.is_empty);
            compare_field("is_full", want.is_full, seen.is_full);
            compare_field("error", want.error, seen.error);
        endfunction
    endclass

endpackage

/* tb/sv/tb_ring_buffer_index_manager.sv */
// Testbench for ring_buffer_index_manager: directed corner requests, then random
// requests over a range of capacities, with random idle and stall on both sides.
// Depends on rbim_pkg, tb_rbim_report_pkg and the block's RTL.
module tb_ring_buffer_index_manager;
    import rbim_pkg::*;
    import tb_rbim_report_pkg::*;

    localparam int MaxSlots     = 1024;
    localparam int WatchLimit   = 2000;
    localparam int SettleCycles = 6;
    localparam int PhaseCount   = 11;
    localparam int SteadyPhase  = 5;
    localparam int PressureAt   = 290;

    // Kind codes the block ignores
    localparam logic [KindW-1:0] KindSpareA = 3'd5;
    localparam logic [KindW-1:0] KindSpareB = 3'd6;
    localparam logic [KindW-1:0] KindSpareC = 3'd7;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_wen       = 1'b0;
    logic [SlotW-1:0]    i_cfg_wdata     = '0;
    logic                i_in_valid      = 1'b0;
    logic [KindW-1:0]    i_kind          = '0;
    logic [FieldW-1:0]   i_request_count = '0;
    logic                i_out_stall     = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [FieldW-1:0]   o_start_offset;
    logic [FieldW-1:0]   o_first_run;
    logic [FieldW-1:0]   o_second_run;
    logic [FieldW-1:0]   o_granted;
    logic [FieldW-1:0]   o_used_count;
    logic [FieldW-1:0]   o_free_count;
    logic                o_is_empty;
    logic                o_is_full;
    logic                o_error;

    ring_report_board    board;
    logic                steady      = 1'b0;
    int unsigned         idle_cycles = 0;
    int unsigned         sent_words  = 0;

    // Capacity per random phase and the number of requests in each
    logic [SlotW-1:0] phase_slots [PhaseCount] =
        '{11'd16, 11'd2, 11'd0, 11'd3, 11'd1, 11'd1023, 11'd2047, 11'd5, 11'd100,
          11'd1500, SlotReset};
    int unsigned      phase_items [PhaseCount] =
        '{60, 30, 20, 30, 20, 80, 60, 40, 80, 60, 70};

    ring_buffer_index_manager #(
        .MAX_SLOTS(MaxSlots)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_request_count(i_request_count),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_start_offset(o_start_offset),
        .o_first_run(o_first_run),
        .o_second_run(o_second_run),
        .o_granted(o_granted),
        .o_used_count(o_used_count),
        .o_free_count(o_free_count),
        .o_is_empty(o_is_empty),
        .o_is_full(o_is_full),
        .o_error(o_error)
    );

    always #5 i_clk = ~i_clk;

    // Stall the output at random except during the steady stretch
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 32);
    end

    // Check each accepted word; end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_report({o_start_offset, o_first_run, o_second_run, o_granted,
                                o_used_count, o_free_count, o_is_empty, o_is_full,
                                o_error});
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WatchLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one request word, hold it until accepted, then maybe idle
    task automatic send_word(input logic [KindW-1:0] kind, input logic [FieldW-1:0] count);
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_request_count <= count;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(kind, count);
        sent_words++;
        if (!steady && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 32);
        end
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.due_reports.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_slot_count(input logic [SlotW-1:0] value);
        drain();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        board.set_slot_count(value);
    endtask

    // Mostly counts up to the legal bound, some just past it, some zero, some anywhere in the field
    function automatic logic [FieldW-1:0] pick_count(int unsigned bound);
        int unsigned roll = $urandom_range(99);
        if (roll < 10) begin
            return '0;
        end
        if (roll < 20) begin
            return FieldW'($urandom_range(1023));
        end
        if (roll < 30) begin
            return FieldW'((bound < 1023) ? bound + 1 : bound);
        end
        if (roll < 40) begin
            return FieldW'(bound);
        end
        return FieldW'($urandom_range(bound));
    endfunction

    initial begin
        int unsigned      roll;
        logic [KindW-1:0] kind;

        board = new(MaxSlots);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners at the reset capacity
        send_word(KIND_RESERVE, 10'd0);
        send_word(KIND_PEEK, 10'd5);
        send_word(KIND_REL_EXACT, 10'd0);
        send_word(KIND_REL_UPTO, 10'd7);
        send_word(KIND_COMMIT, 10'd0);
        send_word(KIND_COMMIT, 10'd1023);
        send_word(KIND_RESERVE, 10'd0);
        send_word(KIND_COMMIT, 10'd1);
        send_word(KIND_PEEK, 10'd0);
        send_word(KIND_PEEK, 10'd1023);
        send_word(KIND_REL_EXACT, 10'd1000);
        send_word(KIND_REL_UPTO, 10'd1023);
        // empty buffer with the head at the last slot
        send_word(KIND_RESERVE, 10'd0);
        send_word(KIND_COMMIT, 10'd50);
        send_word(KIND_PEEK, 10'd30);
        send_word(KIND_RESERVE, 10'd0);
        send_word(KIND_REL_EXACT, 10'd51);
        send_word(KIND_REL_EXACT, 10'd50);
        send_word(KindSpareA, 10'd1023);
        send_word(KindSpareB, 10'd0);
        send_word(KindSpareC, 10'h2AA);
        send_word(KIND_COMMIT, 10'd1023);
        send_word(KIND_REL_UPTO, 10'd0);
        send_word(KIND_REL_EXACT, 10'd1023);

        // Random requests, one capacity per phase
        for (int p = 0; p < PhaseCount; p++) begin
            write_slot_count(phase_slots[p]);
            steady <= (p == SteadyPhase);
            repeat (phase_items[p]) begin
                roll = $urandom_range(99);
                if (roll < 15) begin
                    kind = KIND_RESERVE;
                end else if (roll < 45) begin
                    kind = KIND_COMMIT;
                end else if (roll < 60) begin
                    kind = KIND_PEEK;
                end else if (roll < 75) begin
                    kind = KIND_REL_EXACT;
                end else if (roll < 90) begin
                    kind = KIND_REL_UPTO;
                end else begin
                    kind = KindW'($urandom_range(int'(KindSpareC), int'(KindSpareA)));
                end
                send_word(kind, pick_count((kind == KIND_COMMIT) ? board.free_slots()
                                                                 : board.occupancy()));
                if (sent_words == PressureAt) begin
                    drain();
                end
            end
        end

        drain();
        $display("Checked %0d words from %0d requests over %0d capacity settings",
                 board.checked, sent_words, PhaseCount + 1);
        $display("(wrapped runs, full and empty buffers, illegal commits and releases).");
        if (board.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
